FILE: rtl/core/oss_pkg.sv
`default_nettype none

package oss_pkg;

  // Request codes carried on in_tuser
  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_DELETE = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;
  localparam logic [1:0] ACT_SPARE  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NOCHANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_QUERY    = 2'd3;

  // Width of the reported entry count
  localparam int unsigned OUT_CNT_W = 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } oss_state_t;

  // Read address selection for the store
  typedef enum logic [1:0] {
    RD_ZERO,
    RD_NEXT,
    RD_SKIP
  } oss_rd_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;
    oss_rd_t rd_sel;
    logic    idx_inc;
    logic    mark_hit;
    logic    shift_wr;
    logic    commit;
  } oss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic hit;
    logic scan_end;
    logic is_delete;
    logic out_free;
  } oss_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/oss_ctrl.sv
`default_nettype none

module oss_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_tvalid,
  output logic                    in_tready,
  input  wire oss_pkg::oss_stat_t stat,
  output oss_pkg::oss_cmd_t       cmd
);

  oss_pkg::oss_state_t state_r;
  oss_pkg::oss_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= oss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd          = '0;
    cmd.rd_sel   = oss_pkg::RD_ZERO;
    unique case (state_r)
      oss_pkg::S_IDLE: begin
        // Take no item while reset is held
        in_tready  = rst_n;
        cmd.rd_sel = oss_pkg::RD_ZERO;
        if (in_tvalid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = stat.cnt_zero ? oss_pkg::S_FINISH : oss_pkg::S_SCAN;
        end
      end
      oss_pkg::S_SCAN: begin
        cmd.rd_sel = oss_pkg::RD_NEXT;
        if (stat.hit) begin
          cmd.mark_hit = 1'b1;
          state_nxt    = stat.is_delete ? oss_pkg::S_SHIFT : oss_pkg::S_FINISH;
        end else if (stat.scan_end) begin
          state_nxt = oss_pkg::S_FINISH;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      oss_pkg::S_SHIFT: begin
        cmd.rd_sel = oss_pkg::RD_SKIP;
        if (stat.scan_end) begin
          state_nxt = oss_pkg::S_FINISH;
        end else begin
          cmd.shift_wr = 1'b1;
          cmd.idx_inc  = 1'b1;
        end
      end
      oss_pkg::S_FINISH: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = oss_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = oss_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/oss_datapath.sv
`default_nettype none

module oss_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [1:0]         in_action,
  input  wire  [31:0]        in_element,
  input  wire oss_pkg::oss_cmd_t cmd,
  output oss_pkg::oss_stat_t stat,
  output logic               out_valid,
  input  wire                out_ready,
  output logic               out_was_member,
  output logic [oss_pkg::OUT_CNT_W-1:0] out_entry_count,
  output logic [1:0]         out_status
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rd_data_r;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_data;

  logic [1:0]       act_r;
  logic [31:0]      elem_r;
  logic [IDX_W-1:0] idx_r;
  logic             hit_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] idx_ext;
  logic [CNT_W-1:0] idx_plus;
  logic             ins_ok;
  logic [1:0]       status_nxt;

  logic                          out_valid_r;
  logic                          was_member_r;
  logic [CNT_W+oss_pkg::OUT_CNT_W-1:0] count_wide;
  logic [oss_pkg::OUT_CNT_W-1:0] out_count_r;
  logic [1:0]                    out_status_r;

  assign idx_ext  = CNT_W'(idx_r);
  assign idx_plus = idx_ext + 1'b1;

  // Status toward the controller
  always_comb begin
    stat.cnt_zero  = (count_r == '0);
    stat.hit       = (rd_data_r == elem_r);
    stat.scan_end  = (idx_plus >= count_r);
    stat.is_delete = (act_r == oss_pkg::ACT_DELETE);
    stat.out_free  = !out_valid_r || out_ready;
  end

  // Select the prefetch address
  always_comb begin
    case (cmd.rd_sel)
      oss_pkg::RD_NEXT: rd_addr = idx_r + IDX_W'(1);
      oss_pkg::RD_SKIP: rd_addr = idx_r + IDX_W'(2);
      default:          rd_addr = '0;
    endcase
  end

  // Decide the outcome of the request at commit
  always_comb begin
    count_nxt  = count_r;
    ins_ok     = 1'b0;
    status_nxt = oss_pkg::ST_QUERY;
    unique case (act_r) inside
      oss_pkg::ACT_INSERT: begin
        if (hit_r) begin
          status_nxt = oss_pkg::ST_NOCHANGE;
        end else if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = oss_pkg::ST_FULL;
        end else begin
          ins_ok     = 1'b1;
          count_nxt  = count_r + 1'b1;
          status_nxt = oss_pkg::ST_DONE;
        end
      end
      oss_pkg::ACT_DELETE: begin
        if (hit_r) begin
          count_nxt  = count_r - 1'b1;
          status_nxt = oss_pkg::ST_DONE;
        end else begin
          status_nxt = oss_pkg::ST_NOCHANGE;
        end
      end
      oss_pkg::ACT_QUERY, oss_pkg::ACT_SPARE: begin
        status_nxt = oss_pkg::ST_QUERY;
      end
      default: begin
        status_nxt = oss_pkg::ST_QUERY;
      end
    endcase
  end

  // Store write port: shift down during delete, append on insert
  always_comb begin
    wr_en   = cmd.shift_wr || (cmd.commit && ins_ok);
    wr_addr = cmd.shift_wr ? idx_r : count_r[IDX_W-1:0];
    wr_data = cmd.shift_wr ? rd_data_r : elem_r;
  end

  // Store with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Hold the request and walk the index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      elem_r <= in_element;
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

  // Control state: hit flag, count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (cmd.mark_hit) begin
        hit_r <= 1'b1;
      end
      if (cmd.commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign count_wide = (CNT_W + oss_pkg::OUT_CNT_W)'(count_nxt);

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      was_member_r <= hit_r;
      out_count_r  <= count_wide[oss_pkg::OUT_CNT_W-1:0];
      out_status_r <= status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_member  = was_member_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("result committed over a waiting item");

  a_shift_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift_wr |-> (hit_r && (idx_plus < count_r)))
    else $error("shift outside packed range");

  a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.commit |=> $stable(count_r))
    else $error("count changed without commit");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ordered_set_store.sv
// Ordered set store: holds up to CAPACITY distinct 32-bit values in insertion
// order. Each input item carries a request code on in_tuser (0 insert,
// 1 delete, 2 or 3 membership query) and the element on in_tdata. Each item
// produces exactly one result item on out_tdata: was_member, the entry count
// after the request, and a status (0 done, 1 no change, 2 full, 3 query).
// Requests run one at a time. The store is a single-port-read memory scanned
// one entry per cycle, and a delete moves each later entry down one place
// per cycle through the same port. A request is scanned from the first entry
// until its element is found or the last entry is passed; an empty store is
// not scanned. in_tready is high only in the idle state between requests,
// so a new item is taken only once the last result has been committed.
// Reset empties the set at once; no clearing pass is needed.
// A finished result waits in an output register while the next item is
// accepted and processed; if out_tready stays low the block holds that next
// result until the register frees, and stops accepting meanwhile.
`default_nettype none

module ordered_set_store #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire [31:0] in_tdata,   // [31:0] element
  input  wire [1:0]  in_tuser,   // [1:0] action
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata   // [0] was_member, [5:1] entry_count, [7:6] status
);

  oss_pkg::oss_cmd_t  cmd;
  oss_pkg::oss_stat_t stat;
  logic                          was_member;
  logic [oss_pkg::OUT_CNT_W-1:0] entry_count;
  logic [1:0]                    status;

  oss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oss_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_action       (in_tuser),
    .in_element      (in_tdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_was_member  (was_member),
    .out_entry_count (entry_count),
    .out_status      (status)
  );

  // Pack the result item
  assign out_tdata = {status, entry_count, was_member};

endmodule

`default_nettype wire

FILE: tb/sv/tb_ordered_set_store.sv
`default_nettype none

module tb_ordered_set_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 900;
  localparam int unsigned LONG_HOLD = 120;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  // One result item as carried on out_tdata
  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic       was_member;
  } set_result_t;

  // Tracks the set contents and the results still owed by the block
  class set_scoreboard;
    logic [31:0] members[$];
    set_result_t owed_q[$];
    int unsigned fault_count;

    function void note_request(logic [1:0] act, logic [31:0] elem);
      int slot;
      set_result_t res;
      slot = -1;
      foreach (members[i]) begin
        if (slot < 0 && members[i] == elem) slot = i;
      end
      res.was_member = (slot >= 0);
      case (act)
        oss_pkg::ACT_INSERT: begin
          if (slot >= 0) begin
            res.status = oss_pkg::ST_NOCHANGE;
          end else if (members.size() >= STORE_DEPTH) begin
            res.status = oss_pkg::ST_FULL;
          end else begin
            members.push_back(elem);
            res.status = oss_pkg::ST_DONE;
          end
        end
        oss_pkg::ACT_DELETE: begin
          // Removing from the queue packs later entries down
          if (slot >= 0) begin
            members.delete(slot);
            res.status = oss_pkg::ST_DONE;
          end else begin
            res.status = oss_pkg::ST_NOCHANGE;
          end
        end
        default: res.status = oss_pkg::ST_QUERY;
      endcase
      res.entry_count = 5'(members.size());
      owed_q.push_back(res);
    endfunction

    function void check_result(logic [7:0] data);
      set_result_t got;
      set_result_t want;
      got = set_result_t'(data);
      if (owed_q.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result item %h", $realtime, data);
        return;
      end
      want = owed_q.pop_front();
      if (got.was_member !== want.was_member || got.entry_count !== want.entry_count ||
          got.status !== want.status) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display({"%0t: result mismatch: expected member=%0b count=%0d status=%0d, ",
                    "got member=%0b count=%0d status=%0d"},
                   $realtime, want.was_member, want.entry_count, want.status,
                   got.was_member, got.entry_count, got.status);
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  set_scoreboard sb;
  bit src_idle;
  bit sink_idle;
  bit stall_hold;
  int unsigned idle_cycles;

  ordered_set_store #(.CAPACITY(STORE_DEPTH)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Offer one request and hold it until the block takes it
  task automatic send_request(input logic [1:0] act, input logic [31:0] elem);
    int gap;
    gap = src_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= elem;
    do @(posedge clk); while (!in_tready);
    sb.note_request(act, elem);
  endtask

  // Check every result item taken from the block
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("tb_ordered_set_store: done, errors");
        $finish;
      end
    end
  end

  // Result side: random back-pressure, plus one long hold on request
  initial begin : sink
    int wait_cycles;
    out_tready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (stall_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        stall_hold = 1'b0;
      end
      wait_cycles = sink_idle ? $urandom_range(0, 6) : 0;
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    logic [31:0] pool[20];
    int unsigned sent;
    int unsigned episode;
    int unsigned run_len;
    int unsigned mode;
    int unsigned roll;
    logic [1:0] act;
    logic [31:0] elem;

    sb = new();
    src_idle = 1'b1;
    sink_idle = 1'b1;
    stall_hold = 1'b0;
    idle_cycles = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= oss_pkg::ACT_INSERT;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store, extremes, duplicates, spare code, compaction
    send_request(oss_pkg::ACT_QUERY, 32'h0000_0000);
    send_request(oss_pkg::ACT_DELETE, 32'h1234_5678);
    send_request(oss_pkg::ACT_INSERT, 32'h8000_0000);
    send_request(oss_pkg::ACT_INSERT, 32'h7FFF_FFFF);
    send_request(oss_pkg::ACT_INSERT, 32'h0000_0000);
    send_request(oss_pkg::ACT_INSERT, 32'hFFFF_FFFF);
    send_request(oss_pkg::ACT_INSERT, 32'h7FFF_FFFF);
    send_request(oss_pkg::ACT_SPARE, 32'h8000_0000);
    send_request(oss_pkg::ACT_DELETE, 32'h7FFF_FFFF);
    send_request(oss_pkg::ACT_DELETE, 32'hFFFF_FFFF);
    send_request(oss_pkg::ACT_DELETE, 32'h8000_0000);
    send_request(oss_pkg::ACT_DELETE, 32'hDEAD_BEEF);
    // Fill to capacity, then push past it
    for (int k = 0; k < STORE_DEPTH - 1; k++) send_request(oss_pkg::ACT_INSERT, 32'h1 << k);
    send_request(oss_pkg::ACT_INSERT, 32'h5A5A_5A5A);
    send_request(oss_pkg::ACT_INSERT, 32'h0000_0000);
    send_request(oss_pkg::ACT_QUERY, 32'h0000_4000);

    // Random: episodes over a small value pool so the store fills and empties
    sent = 0;
    episode = 0;
    while (sent < RANDOM_ITEMS) begin
      foreach (pool[i]) begin
        roll = $urandom_range(0, 9);
        pool[i] = (roll == 0) ? 32'h8000_0000 : (roll == 1) ? 32'h7FFF_FFFF : $urandom;
      end
      mode = $urandom_range(0, 2);
      run_len = $urandom_range(20, 60);
      src_idle = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);

      // Long receiver hold while requests keep coming
      if (episode == 3 || episode == 11) begin
        stall_hold = 1'b1;
        src_idle = 1'b0;
      end

      // Sender waits for every owed result before going on
      if (episode == 6 || episode == 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
      end

      repeat (run_len) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: act = (roll < 70) ? oss_pkg::ACT_INSERT :
                   (roll < 85) ? oss_pkg::ACT_DELETE : oss_pkg::ACT_QUERY;
          1: act = (roll < 65) ? oss_pkg::ACT_DELETE :
                   (roll < 85) ? oss_pkg::ACT_INSERT : oss_pkg::ACT_QUERY;
          default: act = (roll < 40) ? oss_pkg::ACT_INSERT :
                         (roll < 75) ? oss_pkg::ACT_DELETE : oss_pkg::ACT_QUERY;
        endcase
        if ($urandom_range(0, 19) == 0) act = oss_pkg::ACT_SPARE;
        elem = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 19)] : $urandom;
        send_request(act, elem);
        sent++;
      end
      episode++;
    end

    // Drain the remaining results, then settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fault_count == 0 && sb.pending() == 0) begin
      $display("tb_ordered_set_store: done, clean");
    end else begin
      $display("tb_ordered_set_store: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/oss_pkg.sv
rtl/core/oss_ctrl.sv
rtl/core/oss_datapath.sv
rtl/core/ordered_set_store.sv
tb/sv/tb_ordered_set_store.sv
